[rtl/resource_pool_counter_macros.svh]
// Assertion macros shared by the resource pool counter RTL.
`ifndef RESOURCE_POOL_COUNTER_MACROS_SVH
`define RESOURCE_POOL_COUNTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("resource pool counter: implication check failed");

// Next-cycle implication, checked outside reset.
`define RPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("resource pool counter: next-cycle check failed");

`endif

[rtl/rpc_pkg.sv]
// Package for the resource pool counter: request codes, defaults and bundles.
package rpc_pkg;

	localparam int NUM_RESOURCES_DEF = 16;
	localparam int COUNT_BITS_DEF    = 16;

	localparam int KIND_BITS  = 3;
	localparam int RID_BITS   = 4;
	localparam int COUNT_OUT_BITS = 16;

	// Request kinds
	localparam logic [KIND_BITS-1:0] KIND_CLEAR = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_LOAD  = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_CHECK = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_TAKE  = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_GIVE  = 3'd4;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [RID_BITS-1:0]  resource_id;
		logic                 last;
	} rpc_req_t;

	typedef struct packed {
		logic [COUNT_OUT_BITS-1:0] count;
		logic                      defined;
		logic                      verdict_valid;
		logic                      contained;
		logic                      underflow;
	} rpc_res_t;

endpackage

[rtl/rpc_table.sv]
// Resource table: per-entry counts, defined marks, check tallies and the update logic.
module rpc_table #(
	parameter int NUM_RESOURCES = rpc_pkg::NUM_RESOURCES_DEF,
	parameter int COUNT_BITS    = rpc_pkg::COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  rpc_pkg::rpc_req_t req,
	output rpc_pkg::rpc_res_t res
);
	import rpc_pkg::*;

	// Only identifiers that fit the id field can ever reach an entry
	localparam int DEPTH    = (NUM_RESOURCES < (1 << RID_BITS)) ? NUM_RESOURCES
	                                                            : (1 << RID_BITS);
	localparam int IDX_BITS = $clog2(DEPTH);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

	logic [COUNT_BITS-1:0] cnt_q   [DEPTH];
	logic [COUNT_BITS-1:0] tally_q [DEPTH];
	logic [DEPTH-1:0]      def_q;
	logic                  failed_q;

	logic                  in_range;
	logic [IDX_BITS-1:0]   idx;
	logic [COUNT_BITS-1:0] cnt_rd;
	logic [COUNT_BITS-1:0] tally_rd;
	logic                  def_rd;
	logic [COUNT_BITS-1:0] cnt_wr;
	logic                  def_wr;
	logic                  wr_entry;
	logic                  tally_inc;
	logic                  failed_nx;
	logic                  clr_all;
	logic                  clr_check;
	logic                  def_out;

	assign in_range = (32'(req.resource_id) < DEPTH);
	assign idx      = req.resource_id[IDX_BITS-1:0];

	// Read the addressed entry; out-of-range ids read as undefined, zero
	always_comb begin
		cnt_rd   = '0;
		tally_rd = '0;
		def_rd   = 1'b0;
		if (in_range) begin
			cnt_rd   = cnt_q[idx];
			tally_rd = tally_q[idx];
			def_rd   = def_q[idx];
		end
	end

	// Per-kind update of the addressed entry and the result flags
	always_comb begin
		cnt_wr    = cnt_rd;
		def_wr    = def_rd;
		wr_entry  = 1'b0;
		tally_inc = 1'b0;
		failed_nx = failed_q;
		clr_all   = 1'b0;
		clr_check = 1'b0;
		def_out   = def_rd;
		res       = '0;
		case (req.kind)
			KIND_CLEAR: begin
				clr_all = 1'b1;
				def_out = 1'b0;
			end
			KIND_LOAD: begin
				if (in_range) begin
					wr_entry = 1'b1;
					def_wr   = 1'b1;
					def_out  = 1'b1;
					if (!def_rd) begin
						cnt_wr = CNT_ONE;
					end else if (cnt_rd != CNT_MAX) begin
						cnt_wr = cnt_rd + CNT_ONE;
					end
				end
			end
			KIND_CHECK: begin
				if (!failed_q) begin
					if (!def_rd || (tally_rd >= cnt_rd)) begin
						failed_nx = 1'b1;
					end else begin
						tally_inc = 1'b1;
					end
				end
				if (req.last) begin
					clr_check         = 1'b1;
					res.verdict_valid = 1'b1;
					res.contained     = !failed_nx;
				end
			end
			KIND_TAKE: begin
				if (def_rd) begin
					if (cnt_rd == '0) begin
						res.underflow = 1'b1;
					end else begin
						wr_entry = 1'b1;
						cnt_wr   = cnt_rd - CNT_ONE;
					end
				end
			end
			KIND_GIVE: begin
				if (def_rd && (cnt_rd != CNT_MAX)) begin
					wr_entry = 1'b1;
					cnt_wr   = cnt_rd + CNT_ONE;
				end
			end
			default: begin
			end
		endcase
		res.defined = def_out;
		res.count   = def_out ? COUNT_OUT_BITS'(cnt_wr) : '0;
	end

	// Table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				cnt_q[i]   <= '0;
				tally_q[i] <= '0;
			end
			def_q    <= '0;
			failed_q <= 1'b0;
		end else if (en) begin
			if (clr_all) begin
				for (int i = 0; i < DEPTH; i++) begin
					cnt_q[i]   <= '0;
					tally_q[i] <= '0;
				end
				def_q    <= '0;
				failed_q <= 1'b0;
			end else begin
				if (wr_entry) begin
					cnt_q[idx] <= cnt_wr;
					def_q[idx] <= def_wr;
				end
				if (clr_check) begin
					for (int i = 0; i < DEPTH; i++) begin
						tally_q[i] <= '0;
					end
					failed_q <= 1'b0;
				end else begin
					failed_q <= failed_nx;
					if (tally_inc) begin
						tally_q[idx] <= tally_rd + CNT_ONE;
					end
				end
			end
		end
	end

endmodule

[rtl/resource_pool_counter.sv]
// Top level of the resource pool counter: request register, table and result register.
//
// Requests (kind, resource_id, last) enter on req_valid/req_ready; one result
// per request leaves on res_valid/res_ready with count, defined,
// verdict_valid, contained and underflow.
// A result is computed by the table from the request register and loaded
// into the result register when that register is free or being read.
// Throughput: one request per cycle while results are taken; the table reads
// the addressed entry combinationally and writes it back on advance, so
// back-to-back requests see each other's updates.
// When the receiver stalls, the result register holds its result and the
// request register can still take one more request; req_ready drops only
// when both are full.
// Reset (arst_n low) empties both registers, zeroes all counts, defined
// marks and check tallies, and abandons any check list in progress.
// A clear request does the same to the table without disturbing the
// handshake.
`include "resource_pool_counter_macros.svh"

module resource_pool_counter #(
	parameter int NUM_RESOURCES = rpc_pkg::NUM_RESOURCES_DEF,
	parameter int COUNT_BITS    = rpc_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic [rpc_pkg::KIND_BITS-1:0]      kind,
	input  logic [rpc_pkg::RID_BITS-1:0]       resource_id,
	input  logic                               last,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic [rpc_pkg::COUNT_OUT_BITS-1:0] count,
	output logic                               defined,
	output logic                               verdict_valid,
	output logic                               contained,
	output logic                               underflow
);
	import rpc_pkg::*;

	rpc_req_t req_s1;
	logic     valid_s1;
	rpc_res_t res_nx;
	rpc_res_t res_q;
	logic     valid_q;
	logic     advance;

	// Stage 1 moves into the result register when that slot is free
	assign advance   = valid_s1 && (!valid_q || res_ready);
	assign req_ready = !valid_s1 || advance;

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1.kind        <= kind;
			req_s1.resource_id <= resource_id;
			req_s1.last        <= last;
		end
	end

	rpc_table #(
		.NUM_RESOURCES (NUM_RESOURCES),
		.COUNT_BITS    (COUNT_BITS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.req    (req_s1),
		.res    (res_nx)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nx;
		end
	end

	assign res_valid     = valid_q;
	assign count         = res_q.count;
	assign defined       = res_q.defined;
	assign verdict_valid = res_q.verdict_valid;
	assign contained     = res_q.contained;
	assign underflow     = res_q.underflow;

	// Checks on the datapath and the internal pipeline
	`RPC_ASSERT_IMPL(a_contained_needs_verdict, clk, arst_n,
		valid_q && res_q.contained, res_q.verdict_valid)
	`RPC_ASSERT_IMPL(a_underflow_at_zero, clk, arst_n,
		valid_q && res_q.underflow, res_q.defined && (res_q.count == '0))
	`RPC_ASSERT_IMPL(a_verdict_not_take, clk, arst_n,
		valid_q && res_q.verdict_valid, !res_q.underflow)
	`RPC_ASSERT_NEXT(a_stage1_holds, clk, arst_n,
		valid_s1 && !advance, valid_s1 && $stable(req_s1))

endmodule
